@@ hw/rtl/tpg_pkg.sv @@
// Shared types, codes and constants for the turtle path generator.
// Used by symbol_turtle_path_generator, tpg_checker and the testbench; no dependencies.
package tpg_pkg;

    localparam int ALPHABET_SIZE_DEF = 64;
    localparam int TRIG_BITS_DEF     = 16;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int ATAN_DEPTH        = 24;

    localparam logic [9:0]  LINE_LENGTH_RST = 10'd35;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    typedef enum logic [1:0] {
        REQ_STEP        = 2'd0,
        REQ_APPEND_STEP = 2'd1,
        REQ_APPEND      = 2'd2,
        REQ_RESTART     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_STEP    = 3'd0,
        CFG_LINE_LENGTH   = 3'd1,
        CFG_START_X       = 3'd2,
        CFG_START_Y       = 3'd3,
        CFG_START_HEADING = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] symbol;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
    } out_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/tpg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/symbol_turtle_path_generator.sv @@
// Turtle path generator top level: alphabet scan, iterative CORDIC, pen and box update.
// Depends on tpg_pkg and tpg_ram.
//
// Input channel s_valid/s_ready/s_data carries one request (step, append then step,
// append only, restart) with a symbol code. Output channel m_valid/m_ready/m_data
// returns exactly one result per request: status, pen position, heading, bounding box.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); start values
// take effect at reset and at the next restart.
// One request is in work at a time; s_ready is high only while the sequencer idles.
// Path from acceptance to m_valid:
//   restart, append only, full alphabet, empty alphabet: straight to the result
//   step matching alphabet slot k: scan of slots 0..k, CORDIC, MUL_X, ADD_X, MUL_Y, ADD_Y
//   unknown symbol: scan of every slot in the alphabet
// The alphabet memory is scanned one slot at a time, each through ST_READ and ST_CMP (one read
// port, registered read), and one add/shift unit runs TRIG_BITS CORDIC iterations, one per cycle.
// One multiplier scales cosine then sine by line_length.
// A result register sits at the output: the next request is accepted while a result
// waits; if the receiver stalls, the following result holds in the block until taken.
// Synchronous reset clears the alphabet count, loads config defaults and puts pen,
// heading and box at the origin.
module symbol_turtle_path_generator
    import tpg_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int TRIG_BITS     = TRIG_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CW    = $clog2(ALPHABET_SIZE + 1);
    localparam int XW    = TRIG_BITS + 2;
    localparam int PW    = XW + 11;
    localparam int SHIFT = TRIG_BITS - 8;
    localparam int DW    = PW - SHIFT;

    localparam logic [CW-1:0]        ALPHA_FULL = CW'(ALPHABET_SIZE);
    localparam logic [4:0]           IT_LAST    = 5'(TRIG_BITS - 1);
    localparam logic signed [XW-1:0] X_INIT     = XW'(CORDIC_GAIN_Q30 >> (30 - TRIG_BITS));
    localparam logic signed [PW-1:0] HALF       = PW'((1 << SHIFT) >> 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_ROT,
        ST_MUL_X,
        ST_ADD_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        angle_step_reg;
    logic [9:0]         line_len_reg;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic [15:0]        start_head_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        heading_reg, heading_next;
    logic [15:0]        cand_reg, cand_next;
    logic signed [31:0] pen_x_reg, pen_x_next, pen_y_reg, pen_y_next;
    logic signed [31:0] min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic signed [31:0] max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic [7:0]         sym_reg, sym_next;
    status_t            status_reg, status_next;
    logic [CW-1:0]      k_reg, k_next;
    logic signed [XW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] z_reg, z_next;
    logic [4:0]         it_reg, it_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               ram_we;
    logic [7:0]         ram_rdata;
    logic               alpha_full;
    logic               is_append;

    logic signed [XW-1:0] xs, ys, c_val, s_val, mul_op;
    logic signed [31:0]   atan_val;
    logic signed [PW-1:0] mul_a, mul_b, rnd;
    logic signed [DW-1:0] delta;
    logic signed [31:0]   pen_sel, pen_new;
    logic signed [32:0]   sum;

    tpg_ram #(
        .WIDTH (8),
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW)
    ) u_alpha (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_data.symbol),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign alpha_full = (count_reg == ALPHA_FULL);
    assign is_append  = (s_data.req_type == REQ_APPEND) || (s_data.req_type == REQ_APPEND_STEP);
    assign ram_we     = s_ready && s_valid && is_append && !alpha_full;

    // CORDIC micro-rotation
    assign xs       = cx_reg >>> it_reg;
    assign ys       = cy_reg >>> it_reg;
    assign atan_val = $signed(atan_turn32(it_reg));

    always_comb begin
        case (heading_reg[15:14])
            2'd0: begin
                c_val = cx_reg;
                s_val = cy_reg;
            end
            2'd1: begin
                c_val = -cy_reg;
                s_val = cx_reg;
            end
            2'd2: begin
                c_val = -cx_reg;
                s_val = -cy_reg;
            end
            default: begin
                c_val = cy_reg;
                s_val = -cx_reg;
            end
        endcase
    end

    // shared multiplier, then round and saturating add
    assign mul_op  = (state_reg == ST_MUL_X) ? c_val : s_val;
    assign mul_a   = PW'($signed({1'b0, line_len_reg}));
    assign mul_b   = PW'(mul_op);
    assign rnd     = (prod_reg + HALF) >>> SHIFT;
    assign delta   = rnd[DW-1:0];
    assign pen_sel = (state_reg == ST_ADD_X) ? pen_x_reg : pen_y_reg;
    assign sum     = 33'(pen_sel) + 33'(delta);
    assign pen_new = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                          : sum[31:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        heading_next = heading_reg;
        cand_next    = cand_reg;
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        min_x_next   = min_x_reg;
        min_y_next   = min_y_reg;
        max_x_next   = max_x_reg;
        max_y_next   = max_y_reg;
        sym_next     = sym_reg;
        status_next  = status_reg;
        k_next       = k_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        z_next       = z_reg;
        it_next      = it_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sym_next    = s_data.symbol;
                    status_next = STAT_DONE;
                    k_next      = '0;
                    cand_next   = heading_reg + angle_step_reg;
                    state_next  = ST_DONE;
                    case (s_data.req_type)
                        REQ_RESTART: begin
                            heading_next = start_head_reg;
                            pen_x_next   = start_x_reg;
                            pen_y_next   = start_y_reg;
                            min_x_next   = start_x_reg;
                            min_y_next   = start_y_reg;
                            max_x_next   = start_x_reg;
                            max_y_next   = start_y_reg;
                        end
                        REQ_STEP: begin
                            if (count_reg == '0) begin
                                status_next = STAT_UNKNOWN;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            if (alpha_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                                if (s_data.req_type == REQ_APPEND_STEP) begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (ram_rdata == sym_reg) begin
                    heading_next = cand_reg;
                    cx_next      = X_INIT;
                    cy_next      = '0;
                    z_next       = $signed({2'b00, cand_reg[13:0], 16'h0000});
                    it_next      = '0;
                    state_next   = ST_ROT;
                end else if (k_reg + 1'b1 == count_reg) begin
                    status_next = STAT_UNKNOWN;
                    state_next  = ST_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    cand_next  = cand_reg + angle_step_reg;
                    state_next = ST_READ;
                end
            end
            ST_ROT: begin
                if (!z_reg[31]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - atan_val;
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + atan_val;
                end
                it_next = it_reg + 1'b1;
                if (it_reg == IT_LAST) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                pen_x_next = pen_new;
                if (pen_new < min_x_reg) begin
                    min_x_next = pen_new;
                end
                if (pen_new > max_x_reg) begin
                    max_x_next = pen_new;
                end
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                pen_y_next = pen_new;
                if (pen_new < min_y_reg) begin
                    min_y_next = pen_new;
                end
                if (pen_new > max_y_reg) begin
                    max_y_next = pen_new;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.pos_x     = pen_x_reg;
                    m_data_next.pos_y     = pen_y_reg;
                    m_data_next.heading   = heading_reg;
                    m_data_next.box_min_x = min_x_reg;
                    m_data_next.box_min_y = min_y_reg;
                    m_data_next.box_max_x = max_x_reg;
                    m_data_next.box_max_y = max_y_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            angle_step_reg <= '0;
            line_len_reg   <= LINE_LENGTH_RST;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_head_reg <= '0;
            count_reg      <= '0;
            heading_reg    <= '0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
            status_reg     <= STAT_DONE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            heading_reg <= heading_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            min_x_reg   <= min_x_next;
            min_y_reg   <= min_y_next;
            max_x_reg   <= max_x_next;
            max_y_reg   <= max_y_next;
            status_reg  <= status_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ANGLE_STEP:    angle_step_reg <= cfg_wdata[15:0];
                    CFG_LINE_LENGTH:   line_len_reg   <= cfg_wdata[9:0];
                    CFG_START_X:       start_x_reg    <= $signed(cfg_wdata);
                    CFG_START_Y:       start_y_reg    <= $signed(cfg_wdata);
                    CFG_START_HEADING: start_head_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        cand_reg   <= cand_next;
        sym_reg    <= sym_next;
        k_reg      <= k_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        z_reg      <= z_next;
        it_reg     <= it_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/tpg_checker.sv @@
// Port-level assertions for symbol_turtle_path_generator, attached by bind.
// Depends on tpg_pkg and the top level's port names.
module tpg_checker
    import tpg_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accepted transaction");

    // a result appears only after work that kept the input side closed
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without work in progress");

    a_box_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.box_min_x) <= $signed(m_data.pos_x))
                 && ($signed(m_data.pos_x) <= $signed(m_data.box_max_x)))
        else $error("pen x outside bounding box");

    a_box_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.box_min_y) <= $signed(m_data.pos_y))
                 && ($signed(m_data.pos_y) <= $signed(m_data.box_max_y)))
        else $error("pen y outside bounding box");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result transaction changed");

endmodule

bind symbol_turtle_path_generator tpg_checker u_tpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/symbol_turtle_path_generator_test.sv @@
// Self-checking bench for symbol_turtle_path_generator: random symbol streams against a
// cycle-free turtle predictor (CORDIC heading walk, saturation, bounding box).
// Depends on tpg_pkg and the block's RTL.
module symbol_turtle_path_generator_test;
    import tpg_pkg::*;

    localparam int     ALPHA    = ALPHABET_SIZE_DEF;
    localparam int     TRIG     = TRIG_BITS_DEF;
    localparam longint GAIN_Q30 = 64'sd652032874;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    symbol_turtle_path_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // arctangent of 2^-i, units of 2^-32 turn
    longint arc_turn32 [24] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    // configuration as the block holds it
    bit [15:0] walk_step;
    bit [9:0]  walk_len;
    longint    start_px;
    longint    start_py;
    bit [15:0] start_head;

    // turtle state
    bit [7:0]  alpha_sym [ALPHA];
    int        alpha_cnt;
    bit [15:0] head;
    longint    pen_x;
    longint    pen_y;
    longint    box_lo_x, box_lo_y, box_hi_x, box_hi_y;

    in_t       symbol_requests [$];
    out_t      path_expected [$];
    bit [7:0]  planned_alpha [$];
    int        send_gap_pct    = 0;
    int        ready_stall_pct = 0;
    int        mismatch_count  = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_q8(longint v);
        if (TRIG == 8)
            return v;
        return (v + (longint'(1) << (TRIG - 9))) >>> (TRIG - 8);
    endfunction

    function automatic void restart_pen();
        head     = start_head;
        pen_x    = start_px;
        pen_y    = start_py;
        box_lo_x = start_px;
        box_lo_y = start_py;
        box_hi_x = start_px;
        box_hi_y = start_py;
    endfunction

    function automatic void reset_turtle();
        walk_step  = 16'd0;
        walk_len   = 10'd35;
        start_px   = 0;
        start_py   = 0;
        start_head = 16'd0;
        alpha_cnt  = 0;
        restart_pen();
    endfunction

    function automatic void move_pen();
        longint cx, cy, cz, xs, ys, cc, ss;
        int     i;
        cx = GAIN_Q30 >>> (30 - TRIG);
        cy = 0;
        cz = longint'(head[13:0]) << 16;
        for (i = 0; i < TRIG && i < 24; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - arc_turn32[i];
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + arc_turn32[i];
            end
        end
        case (head[15:14])
            2'd0: begin cc = cx;  ss = cy;  end
            2'd1: begin cc = -cy; ss = cx;  end
            2'd2: begin cc = -cx; ss = -cy; end
            default: begin cc = cy; ss = -cx; end
        endcase
        pen_x = clamp32(pen_x + scale_q8(longint'(walk_len) * cc));
        pen_y = clamp32(pen_y + scale_q8(longint'(walk_len) * ss));
        if (pen_x < box_lo_x) box_lo_x = pen_x;
        if (pen_y < box_lo_y) box_lo_y = pen_y;
        if (pen_x > box_hi_x) box_hi_x = pen_x;
        if (pen_y > box_hi_y) box_hi_y = pen_y;
    endfunction

    function automatic status_t step_by_symbol(bit [7:0] sym);
        int k;
        for (k = 0; k < alpha_cnt; k++) begin
            if (alpha_sym[k] == sym) begin
                head = 16'(int'(head) + (k + 1) * int'(walk_step));
                move_pen();
                return STAT_DONE;
            end
        end
        return STAT_UNKNOWN;
    endfunction

    function automatic out_t advance_turtle(in_t req);
        out_t    res;
        status_t st;
        st = STAT_DONE;
        case (req.req_type)
            REQ_RESTART: restart_pen();
            REQ_STEP:    st = step_by_symbol(req.symbol);
            default: begin
                if (alpha_cnt >= ALPHA) begin
                    st = STAT_FULL;
                end else begin
                    alpha_sym[alpha_cnt] = req.symbol;
                    alpha_cnt++;
                    if (req.req_type == REQ_APPEND_STEP)
                        st = step_by_symbol(req.symbol);
                end
            end
        endcase
        res.status    = st;
        res.pos_x     = pen_x[31:0];
        res.pos_y     = pen_y[31:0];
        res.heading   = head;
        res.box_min_x = box_lo_x[31:0];
        res.box_min_y = box_lo_y[31:0];
        res.box_max_x = box_hi_x[31:0];
        res.box_max_y = box_hi_y[31:0];
        return res;
    endfunction

    function automatic void compare_field(string field, longint want, longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    function automatic void queue_request(req_t kind, bit [7:0] sym);
        in_t r;
        r.req_type = kind;
        r.symbol   = sym;
        if ((kind == REQ_APPEND || kind == REQ_APPEND_STEP) && planned_alpha.size() < ALPHA)
            planned_alpha = {planned_alpha, sym};
        symbol_requests = {symbol_requests, r};
    endfunction

    function automatic void queue_random_request();
        int       roll;
        bit [7:0] sym;
        roll = $urandom_range(99);
        sym  = 8'($urandom);
        if (roll < 3) begin
            queue_request(REQ_RESTART, sym);
        end else if (roll < 13) begin
            if (planned_alpha.size() != 0 && $urandom_range(9) < 3)
                sym = planned_alpha[$urandom_range(planned_alpha.size() - 1)];
            queue_request($urandom_range(1) ? REQ_APPEND_STEP : REQ_APPEND, sym);
        end else begin
            if (planned_alpha.size() != 0 && $urandom_range(99) < 85)
                sym = planned_alpha[$urandom_range(planned_alpha.size() - 1)];
            queue_request(REQ_STEP, sym);
        end
    endfunction

    task automatic write_register(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ANGLE_STEP:    walk_step  = val[15:0];
            CFG_LINE_LENGTH:   walk_len   = val[9:0];
            CFG_START_X:       start_px   = longint'($signed(val));
            CFG_START_Y:       start_py   = longint'($signed(val));
            CFG_START_HEADING: start_head = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_path(logic [15:0] angle, logic [9:0] len, logic [31:0] sx,
                                logic [31:0] sy, logic [15:0] hd);
        write_register(CFG_ANGLE_STEP, {16'd0, angle});
        write_register(CFG_LINE_LENGTH, {22'd0, len});
        write_register(CFG_START_X, sx);
        write_register(CFG_START_Y, sy);
        write_register(CFG_START_HEADING, {16'd0, hd});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_path_idle();
        while (symbol_requests.size() != 0 || s_valid || path_expected.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // driver: predict on each accepted transaction, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                path_expected = {path_expected, advance_turtle(s_data)};
            if (!s_valid || s_ready) begin
                if (symbol_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_data  <= symbol_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (path_expected.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual status %0d pos %0d,%0d",
                             $time, m_data.status, $signed(m_data.pos_x), $signed(m_data.pos_y));
                end else begin
                    want = path_expected.pop_front();
                    compare_field("status", longint'(want.status), longint'(m_data.status));
                    compare_field("pos_x", longint'($signed(want.pos_x)),
                                  longint'($signed(m_data.pos_x)));
                    compare_field("pos_y", longint'($signed(want.pos_y)),
                                  longint'($signed(m_data.pos_y)));
                    compare_field("heading", longint'(want.heading), longint'(m_data.heading));
                    compare_field("box_min_x", longint'($signed(want.box_min_x)),
                                  longint'($signed(m_data.box_min_x)));
                    compare_field("box_min_y", longint'($signed(want.box_min_y)),
                                  longint'($signed(m_data.box_min_y)));
                    compare_field("box_max_x", longint'($signed(want.box_max_x)),
                                  longint'($signed(m_data.box_max_x)));
                    compare_field("box_max_y", longint'($signed(want.box_max_y)),
                                  longint'($signed(m_data.box_max_y)));
                end
            end
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    initial begin
        int phase;
        reset_turtle();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // default configuration: empty alphabet, duplicates, unknown symbols, restart
        queue_request(REQ_STEP, 8'h41);
        queue_request(REQ_APPEND, 8'h00);
        queue_request(REQ_APPEND_STEP, 8'hFF);
        queue_request(REQ_STEP, 8'h00);
        queue_request(REQ_STEP, 8'hFF);
        queue_request(REQ_APPEND_STEP, 8'h00);
        queue_request(REQ_STEP, 8'h55);
        queue_request(REQ_RESTART, 8'h00);
        queue_request(REQ_APPEND, 8'h55);
        queue_request(REQ_APPEND_STEP, 8'hAA);
        queue_request(REQ_STEP, 8'h55);
        queue_request(REQ_STEP, 8'hAA);
        queue_request(REQ_RESTART, 8'hFF);

        for (phase = 0; phase < 8; phase++) begin
            if (phase > 0) begin
                wait_path_idle();
                case (phase)
                    1: program_path(16'hFFFF, 10'd1023, 32'h7FFF_FF00, 32'h8000_0100, 16'h0000);
                    2: program_path(16'h0000, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
                    default: program_path($urandom_range(3) == 0 ? 16'h4000 : 16'($urandom),
                                          10'($urandom),
                                          $urandom_range(1) ? $urandom
                                                            : 32'($urandom_range(400000)) - 32'd200000,
                                          $urandom_range(1) ? $urandom
                                                            : 32'($urandom_range(400000)) - 32'd200000,
                                          16'($urandom));
                endcase
                queue_request(REQ_RESTART, 8'($urandom));
            end
            case (phase % 4)
                0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_gap_pct = 77; ready_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  ready_stall_pct = 77; end
                default: begin send_gap_pct = 7; ready_stall_pct = 7; end
            endcase
            repeat (phase == 0 ? 100 : 143) queue_random_request();
        end

        wait_path_idle();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && path_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
